// ----- rtl/cubic_bezier_pingpong_path_core_macros.svh -----
// assertion macros for the checker file
// no dependencies
`ifndef CUBIC_BEZIER_PINGPONG_PATH_CORE_MACROS_SVH
`define CUBIC_BEZIER_PINGPONG_PATH_CORE_MACROS_SVH

// antecedent in one cycle implies consequent in the next
`define CBPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the same cycle
`define CBPP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cbpp_pkg.sv -----
// types and constants of the bezier path core
// no dependencies
package cbpp_pkg;

    localparam int MAX_POINTS = 64;
    localparam int PCNT_W     = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int SEG_W      = PCNT_W - 2;
    localparam int T_W        = 19;
    localparam int PARAM_W    = 17;
    localparam int ACC_W      = 52;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_TICK   = 1'b1;
    localparam logic REG_STEP   = 1'b0;
    localparam logic REG_START  = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               evaluated;
        logic [3:0]         segment_index;
    } out_t;

    typedef struct packed {
        logic       append;
        logic       tick_accept;
        logic       prep;
        logic       wgt;
        logic       mac;
        logic [2:0] step;
        logic       round;
        logic       load_out;
        logic       out_eval;
    } cmd_t;

    typedef struct packed {
        logic few;
    } stat_t;

endpackage

// ----- rtl/cubic_bezier_pingpong_path_core.sv -----
// Cubic Bezier path core: an append stores a point and gives no beat. A tick with four
// or more points runs from acceptance to the result beat through a clamp step, six
// passes through the shared weight multiplier, the point reads and three-lane
// multiply-accumulate, a rounding step and the output load; with fewer points a tick
// goes straight to the output load and gives the held position. One item is in work
// at a time; the output register lets the next item be taken while a beat waits.
module cubic_bezier_pingpong_path_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cbpp_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cbpp_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [16:0]    cfg_data
);
    import cbpp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cbpp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_command (in_data.command),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    cbpp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/cbpp_datapath.sv -----
// point store, weight unit, blend lanes and path state
// depends on cbpp_pkg
module cbpp_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  cbpp_pkg::in_t   in_data,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [16:0]     cfg_data,
    input  cbpp_pkg::cmd_t  cmd,
    output cbpp_pkg::stat_t stat,
    output cbpp_pkg::out_t  out_data
);
    import cbpp_pkg::*;

    logic signed [31:0] mem_x [MAX_POINTS];
    logic signed [31:0] mem_y [MAX_POINTS];
    logic signed [31:0] mem_z [MAX_POINTS];

    logic [PCNT_W-1:0]   count_reg;
    logic [SEG_W-1:0]    seg_reg, seg_next, seg_used_reg, last, segc;
    logic signed [T_W-1:0] t_reg;
    logic                rev_reg, rev_next;
    logic [PARAM_W-1:0]  step_reg, start_reg;
    logic [16:0]         u_reg, v_reg;
    logic [33:0]         uu_reg, vv_reg;
    logic [16:0]         w_reg [4];
    logic signed [31:0]  rd_x_reg, rd_y_reg, rd_z_reg;
    logic signed [49:0]  px_reg, py_reg, pz_reg;
    logic signed [ACC_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [31:0]  hx_reg, hy_reg, hz_reg;
    out_t                out_reg;

    logic [33:0]  ma;
    logic [16:0]  mb;
    logic [50:0]  prod;
    logic [52:0]  trip;
    logic [52:0]  wround;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]   widx;
    logic signed [20:0] tw, tn, delta;
    logic [16:0]  uc;
    logic         endhit;

    function automatic logic signed [31:0] rnd_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] b;
        logic signed [ACC_W-17:0] s;
        b = a + ACC_W'(32768);
        s = (ACC_W-16)'(b >>> 16);
        if (s > (ACC_W-16)'(64'sd2147483647))
            rnd_sat = 32'sh7fffffff;
        else if (s < -(ACC_W-16)'(64'sd2147483648))
            rnd_sat = 32'sh80000000;
        else
            rnd_sat = s[31:0];
    endfunction

    assign stat.few = (count_reg < PCNT_W'(4));
    assign out_data = out_reg;

    assign last = SEG_W'(count_reg >> 2) - SEG_W'(1);
    assign segc = (seg_reg > last) ? last : seg_reg;
    assign uc   = (t_reg <= 0) ? 17'd0 :
                  (t_reg > T_W'(65536)) ? 17'd65536 : t_reg[16:0];

    // shared weight multiplier
    always_comb
    begin
        case (cmd.step)
            3'd0:    begin ma = 34'(u_reg); mb = u_reg; end
            3'd1:    begin ma = 34'(v_reg); mb = v_reg; end
            3'd2:    begin ma = vv_reg;     mb = v_reg; end
            3'd3:    begin ma = vv_reg;     mb = u_reg; end
            3'd4:    begin ma = uu_reg;     mb = v_reg; end
            default: begin ma = uu_reg;     mb = u_reg; end
        endcase
        prod   = 51'(ma) * 51'(mb);
        trip   = (cmd.step == 3'd3 || cmd.step == 3'd4) ?
                 (53'(prod) + (53'(prod) << 1)) : 53'(prod);
        wround = trip + 53'h80000000;
    end

    assign rd_addr = {segc[ADDR_W-3:0], cmd.step[1:0]};
    assign widx    = 2'(cmd.step - 3'd1);

    // end handling and step of t
    always_comb
    begin
        tw       = 21'(t_reg);
        seg_next = seg_reg;
        rev_next = rev_reg;
        endhit   = (tw >= 21'sd65536) || (tw <= 21'sd0);
        if (endhit)
        begin
            if (!rev_reg)
            begin
                if (seg_reg < last)
                begin
                    seg_next = seg_reg + SEG_W'(1);
                    tw       = 21'sd0;
                end
                else
                    rev_next = 1'b1;
            end
            else
            begin
                if (seg_reg != '0)
                begin
                    seg_next = seg_reg - SEG_W'(1);
                    tw       = 21'sd65536;
                end
                else
                    rev_next = 1'b0;
            end
        end
        delta = rev_next ? -$signed(21'(step_reg)) : $signed(21'(step_reg));
        tn    = tw + delta;
        if (tn > 21'sd262143)
            tn = 21'sd262143;
        else if (tn < -21'sd262144)
            tn = -21'sd262144;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.append && count_reg < PCNT_W'(MAX_POINTS))
        begin
            mem_x[count_reg[ADDR_W-1:0]] <= in_data.point_x;
            mem_y[count_reg[ADDR_W-1:0]] <= in_data.point_y;
            mem_z[count_reg[ADDR_W-1:0]] <= in_data.point_z;
        end
        if (cmd.mac && !cmd.step[2])
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_z_reg <= mem_z[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            u_reg <= uc;
            v_reg <= 17'd65536 - uc;
        end
        if (cmd.wgt)
        begin
            case (cmd.step)
                3'd0:    uu_reg <= prod[33:0];
                3'd1:    vv_reg <= prod[33:0];
                3'd2:    w_reg[0] <= wround[48:32];
                3'd3:    w_reg[1] <= wround[48:32];
                3'd4:    w_reg[2] <= wround[48:32];
                default: w_reg[3] <= wround[48:32];
            endcase
        end
        if (cmd.mac && cmd.step >= 3'd1 && cmd.step <= 3'd4)
        begin
            px_reg <= $signed({1'b0, w_reg[widx]}) * rd_x_reg;
            py_reg <= $signed({1'b0, w_reg[widx]}) * rd_y_reg;
            pz_reg <= $signed({1'b0, w_reg[widx]}) * rd_z_reg;
        end
        if (cmd.prep)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            az_reg <= '0;
        end
        else if (cmd.mac && cmd.step >= 3'd2)
        begin
            ax_reg <= ax_reg + ACC_W'(px_reg);
            ay_reg <= ay_reg + ACC_W'(py_reg);
            az_reg <= az_reg + ACC_W'(pz_reg);
        end
        if (cmd.load_out)
        begin
            out_reg.pos_x         <= hx_reg;
            out_reg.pos_y         <= hy_reg;
            out_reg.pos_z         <= hz_reg;
            out_reg.evaluated     <= cmd.out_eval;
            out_reg.segment_index <= seg_used_reg[3:0];
        end
        if (cmd.tick_accept)
            seg_used_reg <= seg_reg;
        else if (cmd.prep)
            seg_used_reg <= segc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            seg_reg   <= '0;
            t_reg     <= '0;
            rev_reg   <= 1'b0;
            step_reg  <= PARAM_W'(655);
            start_reg <= '0;
            hx_reg    <= '0;
            hy_reg    <= '0;
            hz_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_STEP)
                    step_reg <= cfg_data;
                else
                begin
                    start_reg <= cfg_data;
                    t_reg     <= T_W'(cfg_data);
                end
            end
            if (cmd.append && count_reg < PCNT_W'(MAX_POINTS))
                count_reg <= count_reg + PCNT_W'(1);
            if (cmd.prep)
                seg_reg <= segc;
            if (cmd.round)
            begin
                hx_reg  <= rnd_sat(ax_reg);
                hy_reg  <= rnd_sat(ay_reg);
                hz_reg  <= rnd_sat(az_reg);
                seg_reg <= seg_next;
                rev_reg <= rev_next;
                t_reg   <= tn[T_W-1:0];
            end
        end
    end

endmodule

// ----- rtl/cbpp_ctrl.sv -----
// sequencing state machine and output valid
// depends on cbpp_pkg
module cbpp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_command,
    output logic            out_valid,
    input  logic            out_ready,
    input  cbpp_pkg::stat_t stat,
    output cbpp_pkg::cmd_t  cmd
);
    import cbpp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_WGT   = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    logic       eval_reg, eval_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        eval_next  = eval_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.step   = cnt_reg;
        cmd.out_eval = eval_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_command == CMD_APPEND)
                        cmd.append = 1'b1;
                    else
                    begin
                        cmd.tick_accept = 1'b1;
                        eval_next  = !stat.few;
                        state_next = stat.few ? ST_OUT : ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_WGT;
            end
            ST_WGT:
            begin
                cmd.wgt  = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                begin
                    cnt_next   = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                cmd.mac  = 1'b1;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd5)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // output register free once the waiting beat leaves
                if (!ov_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            eval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            eval_reg  <= eval_next;
        end
    end

endmodule

// ----- rtl/cbpp_checker.sv -----
// port-level checks for the bezier path core, bound to the top level
// depends on cbpp_pkg and the macros header
`include "cubic_bezier_pingpong_path_core_macros.svh"

module cbpp_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input cbpp_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input cbpp_pkg::out_t out_data
);
    import cbpp_pkg::*;

    // a stalled result beat keeps its payload
    `CBPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    // an accepted tick holds off the next item in the cycle after it
    `CBPP_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_valid && in_ready && in_data.command == CMD_TICK, !in_ready)
    // an append never produces a beat
    `CBPP_ASSERT_NEXT(a_append_quiet, clk, rst_n, in_valid && in_ready && in_data.command == CMD_APPEND && !out_valid, !out_valid)

endmodule

bind cubic_bezier_pingpong_path_core cbpp_checker u_cbpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
